// ===== rtl/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants for the modular exponentiation block: fixed field widths
// and the modulus value after reset.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // fixed widths of the base and exponent fields
  localparam int BASE_W = 32;
  localparam int EXP_W  = 32;

  // step counter must hold the longest multiplier scan
  localparam int CNT_W = $clog2(BASE_W + 1);

  // modulus after reset
  localparam int unsigned MOD_RESET = 997;

endpackage

// ===== rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base ** exponent mod modulus by right-to-left square-and-multiply
// on one shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// One item is in flight at a time; in_stall stays high from the transfer of an
// item until its result has been loaded into the output register. All work
// runs through a single bit-serial modular multiplier that retires one
// multiplier bit per cycle. The base is first reduced by multiplying one by
// the base. Each exponent bit up to the highest set one then takes a square,
// plus a multiply when the bit is set (the square after the highest set bit
// is skipped); the sequencer then ends the scan and loads the result. A zero
// exponent, or a modulus of zero, skips the multiplier and goes straight to
// the result load. A held output register adds its stall cycles before the
// result loads.
// The modulus register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int MOD_BITS = 31,
  parameter int EXP_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  // modulus register write
  input  logic                       modulus_wr_en,
  input  logic [MOD_BITS-1:0]        modulus_wr_data,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [modexp_pkg::BASE_W-1:0] base,
  input  logic [modexp_pkg::EXP_W-1:0]  exponent,
  // output channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [MOD_BITS-1:0]        result
);

  import modexp_pkg::*;

  // exponent bits that take part
  localparam int EU = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
  // width of the shifted partial sum, below three times the modulus
  localparam int SW = MOD_BITS + 2;
  localparam int PAD = BASE_W - MOD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_NEXT,
    S_MUL,
    S_SQR,
    S_FIN
  } state_t;

  state_t               state;
  logic [MOD_BITS-1:0]  modulus;
  logic [MOD_BITS-1:0]  acc;
  logic [MOD_BITS-1:0]  bval;
  logic [EU-1:0]        e_rem;
  logic                 mul_done;
  logic [MOD_BITS-1:0]  prod;
  logic [MOD_BITS-1:0]  mcand;
  logic [BASE_W-1:0]    mplier;
  logic [CNT_W-1:0]     cnt;

  logic [MOD_BITS-1:0]  prod_next;
  logic [SW-1:0]        sum;
  logic [SW-1:0]        diff1;
  logic [SW-1:0]        diff2;
  logic [SW-1:0]        m1;
  logic [SW-1:0]        m2;
  logic [EU-1:0]        e_in;
  logic                 in_xfer;
  logic                 out_free;
  logic                 unit_busy;
  logic                 unit_last;

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_BITS'(MOD_RESET);
    end else if (modulus_wr_en) begin
      modulus <= modulus_wr_data;
    end
  end

  // handshake helpers
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign e_in      = exponent[EU-1:0];
  assign unit_busy = (state == S_RED) || (state == S_MUL) || (state == S_SQR);
  assign unit_last = unit_busy && (cnt == CNT_W'(1));

  // one step of the serial modular multiplier: 2r + a, then reduce
  assign m1    = SW'(modulus);
  assign m2    = {1'b0, modulus, 1'b0};
  assign sum   = {1'b0, prod, 1'b0} + (mplier[BASE_W-1] ? SW'(mcand) : SW'(0));
  assign diff1 = sum - m1;
  assign diff2 = sum - m2;

  always_comb begin
    if (sum >= m2) begin
      prod_next = diff2[MOD_BITS-1:0];
    end else if (sum >= m1) begin
      prod_next = diff1[MOD_BITS-1:0];
    end else begin
      prod_next = sum[MOD_BITS-1:0];
    end
  end

  // sequencer, multiplier registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mul_done  <= 1'b0;
      cnt       <= '0;
    end else begin
      // output register: load a finished result, else drain
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // shared unit advances one multiplier bit
      if (unit_busy) begin
        prod   <= prod_next;
        mplier <= {mplier[BASE_W-2:0], 1'b0};
        cnt    <= cnt - CNT_W'(1);
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            e_rem    <= e_in;
            mul_done <= 1'b0;
            if (e_in == '0) begin
              acc   <= MOD_BITS'(1);
              state <= S_FIN;
            end else if (modulus == '0) begin
              acc   <= '0;
              state <= S_FIN;
            end else begin
              // reduce the base: multiply 1 by the base
              acc    <= MOD_BITS'(1);
              prod   <= '0;
              mcand  <= MOD_BITS'(1);
              mplier <= base;
              cnt    <= CNT_W'(BASE_W);
              state  <= S_RED;
            end
          end
        end
        S_RED: begin
          if (unit_last) begin
            bval  <= prod_next;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          // pick the next operation from the exponent bits left
          prod  <= '0;
          mcand <= bval;
          cnt   <= CNT_W'(MOD_BITS);
          if (e_rem == '0) begin
            state <= S_FIN;
          end else if (e_rem[0] && !mul_done) begin
            mplier <= {acc, PAD'(0)};
            state  <= S_MUL;
          end else if ((e_rem >> 1) == '0) begin
            state <= S_FIN;
          end else begin
            mplier <= {bval, PAD'(0)};
            state  <= S_SQR;
          end
        end
        S_MUL: begin
          if (unit_last) begin
            acc      <= prod_next;
            mul_done <= 1'b1;
            state    <= S_NEXT;
          end
        end
        S_SQR: begin
          if (unit_last) begin
            bval     <= prod_next;
            e_rem    <= e_rem >> 1;
            mul_done <= 1'b0;
            state    <= S_NEXT;
          end
        end
        S_FIN: begin
          if (out_free) begin
            result <= acc;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // partial product stays reduced while the unit runs
  a_prod_reduced: assert property (@(posedge clk) disable iff (rst)
    unit_busy |-> (prod < modulus))
    else $error("partial product not below modulus");

  // the reduced base feeds every multiply and square
  a_base_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_SQR) |-> (bval < modulus))
    else $error("base operand not reduced");

  // the step counter never runs out while the unit is busy
  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    unit_busy |-> (cnt != '0))
    else $error("multiplier step counter empty while busy");

  // a zero exponent goes straight to the result with value one
  a_zero_exp: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && e_in == '0) |=> (state == S_FIN && acc == MOD_BITS'(1)))
    else $error("zero exponent not answered with one");

  // a finished result waits while the output register is held
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && out_stall) |=> (state == S_FIN))
    else $error("result lost while output stalled");

endmodule

// ===== sim/modular_exponentiation_tb.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for the square-and-multiply exponentiation block. A
// scoreboard predicts base ** exponent mod modulus for every transfer into the
// block and checks each result transfer in order. The run covers the edge
// values directed first, then random phases under several modulus settings,
// with random gaps and stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import modexp_pkg::*;

  localparam int MOD_BITS     = 31;
  localparam int EXP_BITS     = 32;
  localparam int IDLE_LIMIT   = 20000;
  localparam int LONG_HOLD    = 3000;
  localparam int SETTLE_WAIT  = 40;
  localparam int MAX_REPORTS  = 10;

  logic                clk;
  logic                rst;
  logic                modulus_wr_en;
  logic [MOD_BITS-1:0] modulus_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic [BASE_W-1:0]   base;
  logic [EXP_W-1:0]    exponent;
  logic                out_valid;
  logic                out_stall;
  logic [MOD_BITS-1:0] result;

  // expected power for one transfer into the block
  typedef struct {
    logic [BASE_W-1:0]   base;
    logic [EXP_W-1:0]    exponent;
    logic [MOD_BITS-1:0] power;
  } power_entry_t;

  // holds the modulus copy and the queue of powers still owed by the block
  class power_scoreboard;
    logic [MOD_BITS-1:0] modulus;
    power_entry_t        owed_powers[$];
    int                  errors;
    int                  checked;

    function new();
      modulus = MOD_RESET[MOD_BITS-1:0];
      errors  = 0;
      checked = 0;
    endfunction

    // right-to-left square-and-multiply on 64-bit values
    function logic [MOD_BITS-1:0] predict_power(logic [BASE_W-1:0] b,
                                                logic [EXP_W-1:0] e);
      longint unsigned m;
      longint unsigned acc;
      longint unsigned sq;
      m = longint'(modulus);
      if (e == '0) return MOD_BITS'(1);
      if (m == 0) return '0;
      sq  = longint'(b) % m;
      acc = 1;
      for (int i = 0; i < EXP_BITS; i++) begin
        if (e[i]) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
      end
      return acc[MOD_BITS-1:0];
    endfunction

    function void note_input(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e);
      power_entry_t ent;
      ent.base     = b;
      ent.exponent = e;
      ent.power    = predict_power(b, e);
      owed_powers.push_back(ent);
    endfunction

    function void check_result(logic [MOD_BITS-1:0] r);
      power_entry_t ent;
      checked++;
      if (owed_powers.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result %0d with nothing owed", $realtime, r);
        return;
      end
      ent = owed_powers.pop_front();
      if (r !== ent.power) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: base %0h exp %0h mod %0d: expected %0d, got %0d",
                   $realtime, ent.base, ent.exponent, modulus, ent.power, r);
      end
    endfunction

    function int pending();
      return owed_powers.size();
    endfunction
  endclass

  power_scoreboard sb;
  bit              hold_req;
  bit              tx_idle_en;
  bit              rx_idle_en;
  int              items_sent;
  int              mod_writes;
  int              idle_cycles;

  modular_exponentiation #(
    .MOD_BITS(MOD_BITS),
    .EXP_BITS(EXP_BITS)
  ) DUT (
    .clk             (clk),
    .rst             (rst),
    .modulus_wr_en   (modulus_wr_en),
    .modulus_wr_data (modulus_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .base            (base),
    .exponent        (exponent),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result          (result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic logic [EXP_W-1:0] pick_exponent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 70) return $urandom_range(1, 255);
    if (r < 85) return $urandom_range(256, 65535);
    return $urandom;
  endfunction

  function automatic logic [BASE_W-1:0] pick_base(logic [MOD_BITS-1:0] m);
    int r;
    r = $urandom_range(0, 99);
    case (r)
      0:       return '0;
      1:       return 1;
      2:       return {1'b0, m} - 1;
      3:       return {1'b0, m};
      4:       return {1'b0, m} + 1;
      5:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // offer one item and hold it until the transfer
  task automatic send_item(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e);
    in_valid <= 1'b1;
    base     <= b;
    exponent <= e;
    do @(posedge clk); while (in_stall);
    sb.note_input(b, e);
    items_sent++;
  endtask

  // one item followed by an optional sender gap
  task automatic run_item(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e);
    int gap;
    send_item(b, e);
    gap = tx_idle_en ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every owed result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_BITS-1:0] v);
    wait_drain();
    modulus_wr_en   <= 1'b1;
    modulus_wr_data <= v;
    @(posedge clk);
    modulus_wr_en <= 1'b0;
    sb.modulus = v;
    mod_writes++;
  endtask

  task automatic random_phase(input int count);
    tx_idle_en = ($urandom_range(0, 9) < 7);
    rx_idle_en = ($urandom_range(0, 9) < 7);
    repeat (count) run_item(pick_base(sb.modulus), pick_exponent());
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        n = rx_idle_en ? gap_len() : 0;
        out_stall <= (n != 0);
        if (n > 1) repeat (n - 1) @(posedge clk);
      end
    end
  end

  // result transfers
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(result);
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [MOD_BITS-1:0] m;
    sb          = new();
    hold_req    = 1'b0;
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    items_sent  = 0;
    mod_writes  = 0;
    idle_cycles = 0;
    rst             <= 1'b1;
    modulus_wr_en   <= 1'b0;
    modulus_wr_data <= '0;
    in_valid        <= 1'b0;
    base            <= '0;
    exponent        <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset modulus, field extremes, bases around the modulus
    run_item(32'h0, 32'h0);
    run_item(32'h0, 32'h1);
    run_item(32'h5, 32'h0);
    run_item(32'hFFFF_FFFF, 32'h0);
    run_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_item(32'h0, 32'hFFFF_FFFF);
    run_item(32'h1, 32'hFFFF_FFFF);
    run_item(32'd996, 32'd2);
    run_item(32'd997, 32'd5);
    run_item(32'd998, 32'd3);
    run_item(32'd2, 32'd10);
    run_item(32'd3, 32'h8000_0000);
    run_item(32'h8000_0000, 32'd1);

    // modulus one: zero exponent still gives one
    write_modulus(31'd1);
    run_item(32'd7, 32'd0);
    run_item(32'd7, 32'd5);

    // modulus zero: result is zero unless the exponent is zero
    write_modulus(31'd0);
    run_item(32'd7, 32'd0);
    run_item(32'd7, 32'd3);
    run_item(32'd0, 32'd0);

    // widest and smallest legal moduli
    write_modulus(31'h7FFF_FFFF);
    run_item(32'h7FFF_FFFE, 32'hFFFF_FFFF);
    run_item(32'hFFFF_FFFF, 32'd2);
    write_modulus(31'd2);
    run_item(32'd3, 32'd3);
    run_item(32'd4, 32'd1);

    // back to the reset value, then random content
    write_modulus(MOD_RESET[MOD_BITS-1:0]);
    random_phase(25);

    // long output hold-off while the sender keeps offering back to back
    wait_drain();
    hold_req   = 1'b1;
    tx_idle_en = 1'b0;
    repeat (8) send_item($urandom, $urandom_range(1, 63));
    wait_drain();

    write_modulus(31'h7FFF_FFFF);
    random_phase(25);
    write_modulus(31'd2);
    random_phase(20);

    // random moduli, zero and one among them
    repeat (7) begin
      case ($urandom_range(0, 7))
        0:       m = 31'd0;
        1:       m = 31'd1;
        2:       m = 31'h7FFF_FFFF;
        3:       m = MOD_BITS'($urandom_range(3, 1000));
        4:       m = 31'd65537;
        default: m = MOD_BITS'($urandom_range(2, 32'h7FFF_FFFF));
      endcase
      write_modulus(m);
      random_phase(25);
    end

    // sender pause between phases until everything owed has come back
    wait_drain();
    random_phase(15);

    wait_drain();
    $display("%0d items and %0d results over %0d modulus writes", items_sent,
             sb.checked, mod_writes);
    $display("covered zero, one, two and full-width moduli, exponents to 32 bits");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors, %0d results still owed", sb.errors, sb.pending());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/modexp_pkg.sv
rtl/modular_exponentiation.sv
sim/modular_exponentiation_tb.sv
